// ----- rtl/qts_pkg.sv -----
// Shared types, token codes, character codes and keyword table for the QASM token scanner.
package qts_pkg;

  localparam int POS_BITS_DEFAULT      = 16;
  localparam int KEYWORD_CHARS_DEFAULT = 8;

  localparam int KW_COUNT     = 14;
  localparam int KW_MAX_CHARS = 8;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } src_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] token_length;
    logic        last_of_run;
  } tok_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } emit_flags_t;

  localparam logic [4:0] K_EOF      = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_NUMBER   = 5'd2;
  localparam logic [4:0] K_STRING   = 5'd3;
  localparam logic [4:0] K_KW_BASE  = 5'd4;
  localparam logic [4:0] K_LBRACKET = 5'd18;
  localparam logic [4:0] K_RBRACKET = 5'd19;
  localparam logic [4:0] K_LPAREN   = 5'd20;
  localparam logic [4:0] K_RPAREN   = 5'd21;
  localparam logic [4:0] K_SEMI     = 5'd22;
  localparam logic [4:0] K_COMMA    = 5'd23;
  localparam logic [4:0] K_ARROW    = 5'd24;
  localparam logic [4:0] K_ERROR    = 5'd25;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM_STR = 2'd2;
  localparam logic [1:0] ERR_LONE_MINUS = 2'd3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // text stored last character first, so byte i of a keyword sits at index i
  localparam logic [KW_MAX_CHARS-1:0][7:0] KW_TEXT [KW_COUNT] = '{
    "MSAQNEPO", "edulcni", "gerq", "gerc", "erusaem", "reirrab", "teser",
    "U", "XC", "etag", "fi", "ip", "nis", "soc"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd8, 4'd7, 4'd4, 4'd4, 4'd7, 4'd7, 4'd5, 4'd1, 4'd2, 4'd4, 4'd2, 4'd2, 4'd3, 4'd3
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic tok_item_t make_tok(input logic [4:0] kind, input logic [1:0] err,
                                         input logic [15:0] ln, input logic [15:0] col,
                                         input logic [15:0] len);
    tok_item_t t;
    t.token_kind   = kind;
    t.error_code   = err;
    t.token_line   = ln;
    t.token_column = col;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

// ----- rtl/qasm_token_scanner.sv -----
// Top level of the QASM token scanner: input register, scanner core and result queue.
//
//   channel | direction | payload      | handshake
//   src     | in        | src_item_t   | src_valid / src_stall
//   tok     | out       | tok_item_t   | tok_valid / tok_stall
//
// A byte enters the input register, is scanned once there is room and its tokens land in
// a four-entry queue; one byte per cycle is taken while the queue has room for two tokens.
// A byte that makes two tokens holds the pace to the one-token-per-cycle output port.
// Reset clears the scanner to line 1, column 1 and empties the queue.
// A stall on tok fills the queue, then raises src_stall while the input register is loaded.
module qasm_token_scanner #(
  parameter int POS_BITS      = qts_pkg::POS_BITS_DEFAULT,
  parameter int KEYWORD_CHARS = qts_pkg::KEYWORD_CHARS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  qts_pkg::src_item_t src_item,
  output logic               tok_valid,
  input  logic               tok_stall,
  output qts_pkg::tok_item_t tok_item
);

  logic                  held_valid;
  qts_pkg::src_item_t    held_item;
  logic                  room;
  logic                  fire;
  qts_pkg::emit_flags_t  emit;
  qts_pkg::tok_item_t    res_a;
  qts_pkg::tok_item_t    res_b;

  assign fire      = held_valid && room;
  assign src_stall = held_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!src_stall) begin
      held_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) held_item <= src_item;
  end

  qts_scan_core #(
    .POS_BITS      (POS_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (held_item),
    .emit  (emit),
    .res_a (res_a),
    .res_b (res_b)
  );

  qts_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .emit  (emit),
    .res_a (res_a),
    .res_b (res_b),
    .room  (room),
    .valid (tok_valid),
    .stall (tok_stall),
    .item  (tok_item)
  );

endmodule

// ----- rtl/qts_scan_core.sv -----
// Scanner state machine: position counters, token buffer, keyword match and up to two results.
module qts_scan_core #(
  parameter int POS_BITS      = qts_pkg::POS_BITS_DEFAULT,
  parameter int KEYWORD_CHARS = qts_pkg::KEYWORD_CHARS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  qts_pkg::src_item_t    item,
  output qts_pkg::emit_flags_t  emit,
  output qts_pkg::tok_item_t    res_a,
  output qts_pkg::tok_item_t    res_b
);

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_INT    = 4'd2;
  localparam logic [3:0] M_FRAC   = 4'd3;
  localparam logic [3:0] M_STRING = 4'd4;
  localparam logic [3:0] M_MINUS  = 4'd5;
  localparam logic [3:0] M_SLASH  = 4'd6;
  localparam logic [3:0] M_LINE   = 4'd7;
  localparam logic [3:0] M_BLOCK  = 4'd8;
  localparam logic [3:0] M_STAR   = 4'd9;
  localparam logic [3:0] M_ERROR  = 4'd10;

  logic [3:0]                     mode, mode_next;
  logic [KEYWORD_CHARS-1:0][7:0]  word_buffer, word_buffer_next;
  logic [15:0]                    cur_len, cur_len_next;
  logic [POS_BITS-1:0]            line_cnt, line_cnt_next;
  logic [POS_BITS-1:0]            col_cnt, col_cnt_next;
  logic [POS_BITS-1:0]            start_line, start_line_next;
  logic [POS_BITS-1:0]            start_col, start_col_next;

  logic [7:0]         c;
  logic               rescan;
  logic               add_en;
  logic [1:0]         n;
  qts_pkg::tok_item_t res [2];
  logic [4:0]         ident_kind;
  logic [15:0]        cur_line16, cur_col16, st_line16, st_col16;

  function automatic logic [15:0] sat_pos(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  always_comb begin
    ident_kind = qts_pkg::K_IDENT;
    for (int k = 0; k < qts_pkg::KW_COUNT; k++) begin
      if (cur_len == 16'(qts_pkg::KW_LEN[k]) &&
          word_buffer[qts_pkg::KW_MAX_CHARS-1:0] == qts_pkg::KW_TEXT[k]) begin
        ident_kind = qts_pkg::K_KW_BASE + 5'(k);
      end
    end
  end

  assign c          = item.char_byte;
  assign cur_line16 = sat_pos(line_cnt);
  assign cur_col16  = sat_pos(col_cnt);
  assign st_line16  = sat_pos(start_line);
  assign st_col16   = sat_pos(start_col);

  always_comb begin
    mode_next        = mode;
    word_buffer_next = word_buffer;
    cur_len_next     = cur_len;
    line_cnt_next    = line_cnt;
    col_cnt_next     = col_cnt;
    start_line_next  = start_line;
    start_col_next   = start_col;
    rescan           = 1'b0;
    add_en           = 1'b0;
    n                = 2'd0;
    res[0]           = '0;
    res[1]           = '0;

    if (item.end_of_input) begin
      case (mode)
        M_IDENT: begin
          res[0] = qts_pkg::make_tok(ident_kind, qts_pkg::ERR_NONE, st_line16, st_col16,
                                     cur_len);
          n = 2'd1;
        end
        M_INT, M_FRAC: begin
          res[0] = qts_pkg::make_tok(qts_pkg::K_NUMBER, qts_pkg::ERR_NONE, st_line16,
                                     st_col16, cur_len);
          n = 2'd1;
        end
        M_STRING: begin
          res[0] = qts_pkg::make_tok(qts_pkg::K_ERROR, qts_pkg::ERR_UNTERM_STR, st_line16,
                                     st_col16, cur_len);
          n = 2'd1;
        end
        M_MINUS: begin
          res[0] = qts_pkg::make_tok(qts_pkg::K_ERROR, qts_pkg::ERR_LONE_MINUS, st_line16,
                                     st_col16, 16'd1);
          n = 2'd1;
        end
        M_SLASH: begin
          res[0] = qts_pkg::make_tok(qts_pkg::K_ERROR, qts_pkg::ERR_UNEXPECTED, st_line16,
                                     st_col16, 16'd1);
          n = 2'd1;
        end
        default: begin
        end
      endcase
      res[n[0]] = qts_pkg::make_tok(qts_pkg::K_EOF, qts_pkg::ERR_NONE, cur_line16,
                                    cur_col16, 16'd0);
      n = n + 2'd1;
      mode_next        = M_IDLE;
      word_buffer_next = '0;
      cur_len_next     = '0;
      line_cnt_next    = POS_BITS'(1);
      col_cnt_next     = POS_BITS'(1);
      start_line_next  = POS_BITS'(1);
      start_col_next   = POS_BITS'(1);
    end else if (mode != M_ERROR) begin
      case (mode)
        M_IDENT: begin
          if (qts_pkg::is_alpha(c) || qts_pkg::is_digit(c) || c == qts_pkg::CH_UNDER) begin
            add_en = 1'b1;
          end else begin
            res[0] = qts_pkg::make_tok(ident_kind, qts_pkg::ERR_NONE, st_line16, st_col16,
                                       cur_len);
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_INT: begin
          if (qts_pkg::is_digit(c)) begin
            add_en = 1'b1;
          end else if (c == qts_pkg::CH_DOT) begin
            add_en = 1'b1;
            mode_next = M_FRAC;
          end else begin
            res[0] = qts_pkg::make_tok(qts_pkg::K_NUMBER, qts_pkg::ERR_NONE, st_line16,
                                       st_col16, cur_len);
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_FRAC: begin
          if (qts_pkg::is_digit(c)) begin
            add_en = 1'b1;
          end else begin
            res[0] = qts_pkg::make_tok(qts_pkg::K_NUMBER, qts_pkg::ERR_NONE, st_line16,
                                       st_col16, cur_len);
            n = 2'd1;
            rescan = 1'b1;
          end
        end
        M_STRING: begin
          if (c == qts_pkg::CH_QUOTE) begin
            res[0] = qts_pkg::make_tok(qts_pkg::K_STRING, qts_pkg::ERR_NONE, st_line16,
                                       st_col16, cur_len);
            n = 2'd1;
            mode_next = M_IDLE;
          end else begin
            add_en = 1'b1;
          end
        end
        M_MINUS: begin
          if (c == qts_pkg::CH_GT) begin
            res[0] = qts_pkg::make_tok(qts_pkg::K_ARROW, qts_pkg::ERR_NONE, st_line16,
                                       st_col16, 16'd2);
            mode_next = M_IDLE;
          end else begin
            res[0] = qts_pkg::make_tok(qts_pkg::K_ERROR, qts_pkg::ERR_LONE_MINUS, st_line16,
                                       st_col16, 16'd1);
            mode_next = M_ERROR;
          end
          n = 2'd1;
        end
        M_SLASH: begin
          if (c == qts_pkg::CH_SLASH) begin
            mode_next = M_LINE;
          end else if (c == qts_pkg::CH_STAR) begin
            mode_next = M_BLOCK;
          end else begin
            res[0] = qts_pkg::make_tok(qts_pkg::K_ERROR, qts_pkg::ERR_UNEXPECTED, st_line16,
                                       st_col16, 16'd1);
            n = 2'd1;
            mode_next = M_ERROR;
          end
        end
        M_LINE: begin
          if (c == qts_pkg::CH_LF) mode_next = M_IDLE;
        end
        M_BLOCK: begin
          if (c == qts_pkg::CH_STAR) mode_next = M_STAR;
        end
        M_STAR: begin
          if (c == qts_pkg::CH_SLASH) mode_next = M_IDLE;
          else if (c != qts_pkg::CH_STAR) mode_next = M_BLOCK;
        end
        M_IDLE: begin
          rescan = 1'b1;
        end
        default: begin
          mode_next = M_ERROR;
        end
      endcase

      if (add_en) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
          if (cur_len == 16'(i)) word_buffer_next[i] = c;
        end
        if (cur_len != 16'hFFFF) cur_len_next = cur_len + 16'd1;
      end

      if (rescan) begin
        mode_next = M_IDLE;
        case (c)
          qts_pkg::CH_SPACE, qts_pkg::CH_TAB, qts_pkg::CH_CR, qts_pkg::CH_LF: begin
          end
          qts_pkg::CH_LBRACK, qts_pkg::CH_RBRACK, qts_pkg::CH_LPAREN, qts_pkg::CH_RPAREN,
          qts_pkg::CH_SEMI, qts_pkg::CH_COMMA: begin
            case (c)
              qts_pkg::CH_LBRACK: res[n[0]].token_kind = qts_pkg::K_LBRACKET;
              qts_pkg::CH_RBRACK: res[n[0]].token_kind = qts_pkg::K_RBRACKET;
              qts_pkg::CH_LPAREN: res[n[0]].token_kind = qts_pkg::K_LPAREN;
              qts_pkg::CH_RPAREN: res[n[0]].token_kind = qts_pkg::K_RPAREN;
              qts_pkg::CH_SEMI:   res[n[0]].token_kind = qts_pkg::K_SEMI;
              default:            res[n[0]].token_kind = qts_pkg::K_COMMA;
            endcase
            res[n[0]].error_code   = qts_pkg::ERR_NONE;
            res[n[0]].token_line   = cur_line16;
            res[n[0]].token_column = cur_col16;
            res[n[0]].token_length = 16'd1;
            res[n[0]].last_of_run  = 1'b0;
            n = n + 2'd1;
          end
          default: begin
            start_line_next  = line_cnt;
            start_col_next   = col_cnt;
            cur_len_next     = '0;
            word_buffer_next = '0;
            if (qts_pkg::is_alpha(c) || qts_pkg::is_digit(c)) begin
              word_buffer_next[0] = c;
              cur_len_next        = 16'd1;
              mode_next = qts_pkg::is_alpha(c) ? M_IDENT : M_INT;
            end else if (c == qts_pkg::CH_QUOTE) begin
              mode_next = M_STRING;
            end else if (c == qts_pkg::CH_MINUS) begin
              mode_next = M_MINUS;
            end else if (c == qts_pkg::CH_SLASH) begin
              mode_next = M_SLASH;
            end else begin
              res[n[0]] = qts_pkg::make_tok(qts_pkg::K_ERROR, qts_pkg::ERR_UNEXPECTED,
                                            cur_line16, cur_col16, 16'd1);
              n = n + 2'd1;
              mode_next = M_ERROR;
            end
          end
        endcase
      end

      if (c == qts_pkg::CH_LF) begin
        if (line_cnt != '1) line_cnt_next = line_cnt + POS_BITS'(1);
        col_cnt_next = POS_BITS'(1);
      end else if (col_cnt != '1) begin
        col_cnt_next = col_cnt + POS_BITS'(1);
      end
    end

    if (n == 2'd2) res[1].last_of_run = 1'b1;
    else if (n == 2'd1) res[0].last_of_run = 1'b1;
  end

  assign emit.first  = fire && (n != 2'd0);
  assign emit.second = fire && (n == 2'd2);
  assign res_a       = res[0];
  assign res_b       = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      word_buffer <= '0;
      cur_len     <= '0;
      line_cnt    <= POS_BITS'(1);
      col_cnt     <= POS_BITS'(1);
      start_line  <= POS_BITS'(1);
      start_col   <= POS_BITS'(1);
    end else if (fire) begin
      mode        <= mode_next;
      word_buffer <= word_buffer_next;
      cur_len     <= cur_len_next;
      line_cnt    <= line_cnt_next;
      col_cnt     <= col_cnt_next;
      start_line  <= start_line_next;
      start_col   <= start_col_next;
    end
  end

endmodule

// ----- rtl/qts_result_fifo.sv -----
// Four-entry result queue: takes up to two tokens per cycle, hands out one unless stalled.
module qts_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  qts_pkg::emit_flags_t  emit,
  input  qts_pkg::tok_item_t    res_a,
  input  qts_pkg::tok_item_t    res_b,
  output logic                  room,
  output logic                  valid,
  input  logic                  stall,
  output qts_pkg::tok_item_t    item
);

  qts_pkg::tok_item_t entries [4];
  logic [1:0]         head;
  logic [1:0]         tail;
  logic [2:0]         count;
  logic               pop;

  assign valid = count != 3'd0;
  assign pop   = valid && !stall;
  assign item  = entries[head];
  assign room  = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (emit.first) entries[tail] <= res_a;
    if (emit.second) entries[tail + 2'd1] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + 2'd1;
      tail  <= tail + 2'({1'b0, emit.first} + {1'b0, emit.second});
      count <= count + 3'(emit.first) + 3'(emit.second) - 3'(pop);
    end
  end

endmodule
